[design/rlpr_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the pan reference generator.
// Used by every module of the block; depends on nothing else.

package rlpr_pkg;

	// Field and port widths
	localparam int VAL_W     = 20;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int PAN_W     = 14;
	localparam int MAXV_W    = 18;
	localparam int MAXA_W    = 20;
	localparam int PHASE_W   = 16;

	// Tick rate, the reciprocal used to divide by it, and the reciprocal used to divide by ten
	localparam int      TICK_RATE_HZ = 50;
	localparam int      TICK_HALF    = TICK_RATE_HZ / 2;
	localparam int      RECIP_SHIFT  = 32;
	localparam longint  TICK_RECIP   = ((64'd1 << RECIP_SHIFT) + TICK_RATE_HZ - 1) / TICK_RATE_HZ;
	localparam longint  TENTH_RECIP  = ((64'd1 << RECIP_SHIFT) + 10 - 1) / 10;

	// Shared multiplier operand and product widths, with the quotient and sum widths
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int QUOT_W  = 21;
	localparam int SUM_W   = 24;

	// Saturation bounds of the 20 bit signed values
	localparam logic signed [SUM_W-1:0] V_MAX = SUM_W'(524287);
	localparam logic signed [SUM_W-1:0] V_MIN = -SUM_W'(524288);

	// Quarter-wave sine table
	localparam int          SINE_TABLE_DEPTH = 256;
	localparam int          SINE_W           = 17;
	localparam int          SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
	localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;

	// Reciprocals of the series divisors 2k(2k+1), rounded up; exact for terms below 2^32
	localparam int          TAYLOR_SHIFT   = 42;
	localparam logic [63:0] TAYLOR_RECIP_1 = ((64'd1 << TAYLOR_SHIFT) + 64'd5) / 64'd6;
	localparam logic [63:0] TAYLOR_RECIP_2 = ((64'd1 << TAYLOR_SHIFT) + 64'd19) / 64'd20;
	localparam logic [63:0] TAYLOR_RECIP_3 = ((64'd1 << TAYLOR_SHIFT) + 64'd41) / 64'd42;
	localparam logic [63:0] TAYLOR_RECIP_4 = ((64'd1 << TAYLOR_SHIFT) + 64'd71) / 64'd72;
	localparam logic [63:0] TAYLOR_RECIP_5 = ((64'd1 << TAYLOR_SHIFT) + 64'd109) / 64'd110;
	localparam logic [63:0] TAYLOR_RECIP_6 = ((64'd1 << TAYLOR_SHIFT) + 64'd155) / 64'd156;
	localparam logic [63:0] TAYLOR_RECIP_7 = ((64'd1 << TAYLOR_SHIFT) + 64'd209) / 64'd210;
	localparam logic [63:0] TAYLOR_RECIP_8 = ((64'd1 << TAYLOR_SHIFT) + 64'd271) / 64'd272;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAN_LIM    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACC    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd3;

	// Register reset values
	localparam logic [PAN_W-1:0]   PAN_LIM_RST    = 14'd6431;
	localparam logic [MAXV_W-1:0]  MAX_VEL_RST    = 18'd16384;
	localparam logic [MAXA_W-1:0]  MAX_ACC_RST    = 20'd49152;
	localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 16'd786;

	// Goal modes
	localparam logic [1:0] MODE_REST   = 2'd0;
	localparam logic [1:0] MODE_SWEEP  = 2'd1;
	localparam logic [1:0] MODE_FOLLOW = 2'd2;
	localparam logic [1:0] MODE_HOLD   = 2'd3;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [VAL_W-1:0] bearing;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] position_ref;
		logic signed [VAL_W-1:0] velocity_ref;
	} out_item_t;

	// Sequencer steps; each step but idle owns one use of the shared multiplier or one update
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AMP,
		ST_SIN,
		ST_TGT,
		ST_VDES,
		ST_ACC,
		ST_VDIV,
		ST_VUPD,
		ST_PDIV,
		ST_PUPD
	} step_t;

	typedef struct packed {
		logic  in_ready;
		logic  mul_en;
		logic  out_load;
		step_t op;
	} rlpr_ctl_t;

	// Pick the reciprocal of the k-th series divisor
	function automatic logic [63:0] taylor_recip(input int k);
		case (k)
			1:       return TAYLOR_RECIP_1;
			2:       return TAYLOR_RECIP_2;
			3:       return TAYLOR_RECIP_3;
			4:       return TAYLOR_RECIP_4;
			5:       return TAYLOR_RECIP_5;
			6:       return TAYLOR_RECIP_6;
			7:       return TAYLOR_RECIP_7;
			default: return TAYLOR_RECIP_8;
		endcase
	endfunction

	// Build the table with a truncated Taylor series in Q30, entry i = sin(i*pi/2/D) in Q16
	function automatic logic [(SINE_TABLE_DEPTH+1)*SINE_W-1:0] build_sine_rom();
		logic [(SINE_TABLE_DEPTH+1)*SINE_W-1:0] rom;
		logic [63:0]  x;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [63:0]  r;
		logic [127:0] wide;
		rom = '0;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
			term = x;
			sum = '0;
			for (int k = 1; k <= 8; k++) begin
				if ((k & 1) != 0) begin
					sum = sum + term;
				end else begin
					sum = sum - term;
				end
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				wide = 128'(term) * 128'(taylor_recip(k));
				term = wide[TAYLOR_SHIFT +: 64];
			end
			r = (sum + 64'd8192) >> 14;
			if (r > 64'd65536) begin
				r = 64'd65536;
			end
			rom[i*SINE_W +: SINE_W] = r[SINE_W-1:0];
		end
		return rom;
	endfunction

	localparam logic [(SINE_TABLE_DEPTH+1)*SINE_W-1:0] SINE_ROM = build_sine_rom();

	function automatic logic [SINE_W-1:0] sine_entry(input logic [SINE_IDX_W-1:0] idx);
		return SINE_ROM[int'(idx)*SINE_W +: SINE_W];
	endfunction

endpackage

[design/rlpr_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on rlpr_pkg for operand and product widths.

module rlpr_mul import rlpr_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [MUL_A_W-1:0]  a,
	input  logic signed [MUL_B_W-1:0]  b,
	output logic signed [PROD_W-1:0]   prod
);

	logic signed [PROD_W-1:0] prod_q;

	// Capture a new product only when a step issues one; hold otherwise
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

[design/rlpr_ctrl.sv]
// Step sequencer for the pan reference generator: walks one item through the shared multiplier.
// Depends on rlpr_pkg for the step enum and the control struct.

module rlpr_ctrl import rlpr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_free,
	output rlpr_ctl_t ctl
);

	step_t state_q;
	step_t state_d;

	// Hold the current step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance through the fixed step order; wait at the last step for room in the output register
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_AMP;
				end
			end
			ST_AMP:  state_d = ST_SIN;
			ST_SIN:  state_d = ST_TGT;
			ST_TGT:  state_d = ST_VDES;
			ST_VDES: state_d = ST_ACC;
			ST_ACC:  state_d = ST_VDIV;
			ST_VDIV: state_d = ST_VUPD;
			ST_VUPD: state_d = ST_PDIV;
			ST_PDIV: state_d = ST_PUPD;
			ST_PUPD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Decode the step into datapath controls
	always_comb begin
		ctl.op       = state_q;
		ctl.in_ready = (state_q == ST_IDLE);
		ctl.out_load = (state_q == ST_PUPD) && out_free;
		case (state_q)
			ST_AMP, ST_SIN, ST_VDES, ST_ACC, ST_VDIV, ST_PDIV: ctl.mul_en = 1'b1;
			default:                                          ctl.mul_en = 1'b0;
		endcase
	end

endmodule

[design/rate_limited_pan_reference.sv]
// Pan reference generator: one input item is one control tick carrying a goal mode and a
// bearing; each item yields exactly one item holding the new position and velocity references.
// An accepted item runs through nine sequencer steps before the next item can be accepted;
// their order is set by the single shared multiplier, which forms six products per item in
// turn (scan amplitude, sine scaling, desired velocity, acceleration and
// two divisions by the tick rate). in_ready is high only while the sequencer is idle; a
// finished item waits in the output register, and the last step stalls only if that register
// is still full. Configuration writes take effect at once and must be made while idle.
// Depends on rlpr_pkg, rlpr_mul and rlpr_ctrl.

module rate_limited_pan_reference import rlpr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	rlpr_ctl_t ctl;
	logic      out_free;

	// Configuration registers
	logic [PAN_W-1:0]   pan_lim_q;
	logic [MAXV_W-1:0]  max_vel_q;
	logic [MAXA_W-1:0]  max_acc_q;
	logic [PHASE_W-1:0] phase_step_q;

	// Tick state and per-item working registers
	logic signed [VAL_W-1:0] pos_q;
	logic signed [VAL_W-1:0] vel_q;
	logic [PHASE_W-1:0]      phase_q;
	logic [1:0]              mode_q;
	logic signed [VAL_W-1:0] bearing_q;
	logic signed [VAL_W-1:0] target_q;
	logic                    neg_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	// Multiplier operands and product
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;

	// Combinational helpers
	logic signed [VAL_W-1:0]   lim_s;
	logic [17:0]               pan9_plus5;
	logic [PAN_W-1:0]          amp;
	logic [14+SINE_IDX_W-1:0]  idx_prod;
	logic [SINE_IDX_W-1:0]     idx;
	logic [SINE_IDX_W-1:0]     rom_idx;
	logic [SINE_W-1:0]         sine_mag;
	logic signed [SINE_W:0]    sine_s;
	logic signed [PROD_W-1:0]  prod_abs;
	logic                      prod_neg;
	logic [15:0]               scan_mag;
	logic signed [VAL_W-1:0]   scan_tgt;
	logic signed [VAL_W-1:0]   target_d;
	logic signed [PROD_W-1:0]  maxv_w;
	logic signed [PROD_W-1:0]  maxa_w;
	logic signed [VAL_W-1:0]   vdes;
	logic [MAXA_W-1:0]         acc_mag;
	logic                      acc_neg;
	logic [VAL_W:0]            vel_mag;
	logic [QUOT_W-1:0]         quot;
	logic signed [SUM_W-1:0]   quot_s;
	logic signed [SUM_W-1:0]   vel_sum;
	logic signed [VAL_W-1:0]   vel_sat;
	logic signed [SUM_W-1:0]   pos_sum;
	logic signed [SUM_W-1:0]   lim_w;
	logic signed [VAL_W-1:0]   pos_clamp;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = ctl.in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	rlpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.ctl      (ctl)
	);

	rlpr_mul u_mul (
		.clk  (clk),
		.en   (ctl.mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_lim_q    <= PAN_LIM_RST;
			max_vel_q    <= MAX_VEL_RST;
			max_acc_q    <= MAX_ACC_RST;
			phase_step_q <= PHASE_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAN_LIM:    pan_lim_q    <= cfg_data[PAN_W-1:0];
				REG_MAX_VEL:    max_vel_q    <= cfg_data[MAXV_W-1:0];
				REG_MAX_ACC:    max_acc_q    <= cfg_data[MAXA_W-1:0];
				REG_PHASE_STEP: phase_step_q <= cfg_data[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	assign lim_s  = VAL_W'({1'b0, pan_lim_q});
	assign lim_w  = SUM_W'({1'b0, pan_lim_q});
	assign maxv_w = PROD_W'({1'b0, max_vel_q});
	assign maxa_w = PROD_W'({1'b0, max_acc_q});

	// Scan amplitude: 9 * limit + 5, divided by ten through the multiplier
	assign pan9_plus5 = (18'(pan_lim_q) << 3) + 18'(pan_lim_q) + 18'd5;
	assign amp        = prod[RECIP_SHIFT +: PAN_W];

	// Quarter-wave lookup of the current phase
	always_comb begin
		idx_prod = (14 + SINE_IDX_W)'(phase_q[13:0]) * (14 + SINE_IDX_W)'(SINE_TABLE_DEPTH);
		idx      = idx_prod[14 +: SINE_IDX_W];
		rom_idx  = phase_q[14] ? (SINE_IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
		sine_mag = sine_entry(rom_idx);
		sine_s   = phase_q[15] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
	end

	// Magnitude and sign of the product, shared by rounding and clamping steps
	assign prod_neg = prod[PROD_W-1];
	assign prod_abs = prod_neg ? -prod : prod;

	// Scaled sine rounded to nearest, halves away from zero
	always_comb begin
		scan_mag = 16'((32'(prod_abs[30:0]) + 32'd32768) >> 16);
		scan_tgt = prod_neg ? -$signed(VAL_W'(scan_mag)) : $signed(VAL_W'(scan_mag));
	end

	// Pick the target for this tick
	always_comb begin
		case (mode_q)
			MODE_SWEEP: target_d = scan_tgt;
			MODE_FOLLOW: begin
				if (bearing_q > lim_s) begin
					target_d = lim_s;
				end else if (bearing_q < -lim_s) begin
					target_d = -lim_s;
				end else begin
					target_d = bearing_q;
				end
			end
			MODE_REST, MODE_HOLD: target_d = pos_q;
			default:              target_d = pos_q;
		endcase
	end

	// Clamp desired velocity
	always_comb begin
		if (prod > maxv_w) begin
			vdes = VAL_W'(maxv_w);
		end else if (prod < -maxv_w) begin
			vdes = -VAL_W'(maxv_w);
		end else begin
			vdes = prod[VAL_W-1:0];
		end
	end

	// Clamp acceleration, kept as sign and magnitude for the rounded division
	always_comb begin
		if (prod > maxa_w) begin
			acc_mag = max_acc_q;
			acc_neg = 1'b0;
		end else if (prod < -maxa_w) begin
			acc_mag = max_acc_q;
			acc_neg = 1'b1;
		end else begin
			acc_mag = prod_abs[MAXA_W-1:0];
			acc_neg = prod_neg;
		end
	end

	assign vel_mag = vel_q[VAL_W-1] ? -(VAL_W + 1)'(vel_q) : (VAL_W + 1)'(vel_q);

	// Quotient of a rounded division by the tick rate, with its sign restored
	always_comb begin
		quot   = prod[RECIP_SHIFT +: QUOT_W];
		quot_s = neg_q ? -$signed(SUM_W'(quot)) : $signed(SUM_W'(quot));
	end

	// Integrate velocity with saturation
	always_comb begin
		vel_sum = SUM_W'(vel_q) + quot_s;
		if (vel_sum > V_MAX) begin
			vel_sat = VAL_W'(V_MAX);
		end else if (vel_sum < V_MIN) begin
			vel_sat = VAL_W'(V_MIN);
		end else begin
			vel_sat = vel_sum[VAL_W-1:0];
		end
	end

	// Integrate position and clamp to the pan limit
	always_comb begin
		pos_sum = SUM_W'(pos_q) + quot_s;
		if (pos_sum > lim_w) begin
			pos_clamp = lim_s;
		end else if (pos_sum < -lim_w) begin
			pos_clamp = -lim_s;
		end else begin
			pos_clamp = pos_sum[VAL_W-1:0];
		end
	end

	// Route operands to the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.op)
			ST_AMP: begin
				mul_a = MUL_A_W'(pan9_plus5);
				mul_b = MUL_B_W'(TENTH_RECIP);
			end
			ST_SIN: begin
				mul_a = MUL_A_W'(amp);
				mul_b = MUL_B_W'(sine_s);
			end
			ST_VDES: begin
				mul_a = MUL_A_W'(target_q) - MUL_A_W'(pos_q);
				mul_b = MUL_B_W'(TICK_RATE_HZ);
			end
			ST_ACC: begin
				mul_a = MUL_A_W'(vdes) - MUL_A_W'(vel_q);
				mul_b = MUL_B_W'(TICK_RATE_HZ);
			end
			ST_VDIV: begin
				mul_a = MUL_A_W'((VAL_W + 1)'(acc_mag) + (VAL_W + 1)'(TICK_HALF));
				mul_b = MUL_B_W'(TICK_RECIP);
			end
			ST_PDIV: begin
				mul_a = MUL_A_W'(vel_mag + (VAL_W + 1)'(TICK_HALF));
				mul_b = MUL_B_W'(TICK_RECIP);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Advance the phase and update tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			vel_q   <= '0;
			phase_q <= '0;
		end else begin
			case (ctl.op)
				ST_AMP: begin
					if (mode_q == MODE_SWEEP) begin
						phase_q <= phase_q + phase_step_q;
					end
				end
				ST_VUPD: vel_q <= vel_sat;
				ST_PUPD: begin
					if (ctl.out_load) begin
						pos_q <= pos_clamp;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the current item
	always_ff @(posedge clk) begin
		case (ctl.op)
			ST_IDLE: begin
				if (in_valid) begin
					mode_q    <= in_data.mode;
					bearing_q <= in_data.bearing;
				end
			end
			ST_TGT:  target_q <= target_d;
			ST_VDIV: neg_q    <= acc_neg;
			ST_PDIV: neg_q    <= vel_q[VAL_W-1];
			default: ;
		endcase
	end

	// Output register: load the finished item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_q.position_ref <= pos_clamp;
			out_q.velocity_ref <= vel_q;
		end
	end

	// A waiting item never carries a position beyond the pan limit
	a_pos_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.position_ref <= lim_s) && (out_q.position_ref >= -lim_s))
		else $error("position reference outside the pan limit");

	// The block goes busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready still high after an accepted item");

	// The sweep phase moves only on the scan step of a scan item
	a_phase_only_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.op == ST_AMP && mode_q == MODE_SWEEP) |=> $stable(phase_q))
		else $error("sweep phase moved outside a scan tick");

	// A finished item is loaded only into a free output register
	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before it was taken");

endmodule
